// File: hdl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and codes for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

  // Operation codes carried by an input word
  typedef enum logic [1:0] {
    KIND_PUSH     = 2'd0,
    KIND_POP      = 2'd1,
    KIND_SEARCH   = 2'd2,
    KIND_TRAVERSE = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Per-cycle action of one storage cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_POP    = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 6;

  // Control bundle sent from the core to every cell
  typedef struct packed {
    cell_op_e op;
    logic     wrap;
  } cell_ctrl_t;

endpackage

// File: hdl/lss_cell.sv
// ----------------------------------------------------------------------------
// lss_cell
// One stack slot: shifts towards the bottom on push, towards the top on pop
// and rotate, and compares its word with the search key.
// ----------------------------------------------------------------------------
module lss_cell
  import lss_pkg::*;
(
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [DataW-1:0] up_data_i,
  input  logic signed [DataW-1:0] down_data_i,
  input  logic signed [DataW-1:0] wrap_data_i,
  input  logic signed [DataW-1:0] key_i,
  output logic signed [DataW-1:0] data_o,
  output logic                    match_o
);

  logic signed [DataW-1:0] data_q, data_d;

  // Select the word this slot takes next
  always_comb begin
    case (ctrl_i.op)
      CELL_HOLD:   data_d = data_q;
      CELL_PUSH:   data_d = up_data_i;
      CELL_POP:    data_d = down_data_i;
      CELL_ROTATE: data_d = ctrl_i.wrap ? wrap_data_i : down_data_i;
      default:     data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

// File: hdl/lifo_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core
// Bounded LIFO stack of signed 32-bit words built as a row of cells, slot 0
// holding the top of the stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per word:
//   push, pop, search or traverse. Output channel (out_valid_o / out_stall_i)
//   returns result words from a single output register.
//   Push, pop and search give one registered result word in the cycle after
//   acceptance; the next input word may be taken in the following cycle,
//   so these run at one word per cycle while the receiver keeps up.
//   Traverse of a stack holding N entries first sets the busy state, then
//   gives N result words, one per cycle while the receiver keeps up, each
//   taken from the top slot into the result register. The row of cells
//   rotates by one slot per emitted word and is back in its original
//   order after the last one. An empty stack traverse gives one empty result.
//   Search compares every slot in parallel and takes the topmost match.
//   Reset empties the stack and drops any pending result; slot contents are
//   not cleared. When the receiver stalls, the result word holds and the
//   input side stalls with it; nothing is lost.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_core
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [DataW-1:0] data_o,
  output logic [PosW-1:0]         position_o,
  output logic                    last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  // Control state
  logic            out_valid_q, out_valid_d;
  logic            busy_q, busy_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] trav_q, trav_d;

  // Result register
  logic [1:0]              status_q, status_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic [PosW-1:0]         pos_q, pos_d;
  logic                    last_q, last_d;

  logic signed [DataW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]        cell_match;
  cell_op_e                cell_op;
  cell_ctrl_t              cell_ctrl [DEPTH];

  logic            out_free;
  logic            in_acc;
  logic            step;
  logic            full;
  logic            empty;
  logic            found;
  logic [IdxW-1:0] hit_idx;
  logic [CntW-1:0] top_cnt;
  logic [CntW-1:0] trav_next;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign step      = busy_q && out_free;
  assign full      = (fill_q == FullCnt);
  assign empty     = (fill_q == '0);
  assign top_cnt   = fill_q - CntW'(1);
  assign trav_next = trav_q + CntW'(1);

  // Row of storage cells, slot 0 on top
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] up_data;
    logic signed [DataW-1:0] down_data;

    if (i == 0) begin : g_top
      assign up_data = value_i;
    end else begin : g_mid
      assign up_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign down_data = cell_data[i];
    end else begin : g_up
      assign down_data = cell_data[i+1];
    end

    assign cell_ctrl[i].op   = cell_op;
    assign cell_ctrl[i].wrap = (top_cnt == CntW'(i));

    lss_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .up_data_i   (up_data),
      .down_data_i (down_data),
      .wrap_data_i (cell_data[0]),
      .key_i       (value_i),
      .data_o      (cell_data[i]),
      .match_o     (cell_match[i])
    );
  end

  // Take the topmost live match
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (CntW'(i) < fill_q)) begin
        found   = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  // Decode the operation and build the next result
  always_comb begin
    cell_op     = CELL_HOLD;
    fill_d      = fill_q;
    busy_d      = busy_q;
    trav_d      = trav_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    data_d      = data_q;
    pos_d       = pos_q;
    last_d      = last_q;

    if (step) begin
      // Emit the top slot and rotate the row by one
      cell_op     = CELL_ROTATE;
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      data_d      = cell_data[0];
      pos_d       = PosW'(trav_q);
      last_d      = (trav_q == top_cnt);
      trav_d      = trav_next;
      if (trav_q == top_cnt) begin
        busy_d = 1'b0;
      end
    end else if (in_acc) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      data_d      = '0;
      pos_d       = '0;
      last_d      = 1'b1;
      case (kind_e'(kind_i))
        KIND_PUSH: begin
          if (full) begin
            status_d = ST_OVERFLOW;
          end else begin
            cell_op = CELL_PUSH;
            fill_d  = fill_q + CntW'(1);
          end
        end
        KIND_POP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cell_op = CELL_POP;
            fill_d  = top_cnt;
            data_d  = cell_data[0];
          end
        end
        KIND_SEARCH: begin
          if (found) begin
            pos_d = PosW'(hit_idx);
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
        KIND_TRAVERSE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            out_valid_d = 1'b0;
            busy_d      = 1'b1;
            trav_d      = '0;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      fill_q      <= '0;
      trav_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      fill_q      <= fill_d;
      trav_q      <= trav_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    pos_q    <= pos_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

  // Checks
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullCnt)
    else $error("fill count beyond depth");

  a_busy_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (fill_q != '0) && (trav_q < fill_q))
    else $error("traverse index outside stack");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_PUSH && !full) |=> fill_q == $past(fill_q) + CntW'(1))
    else $error("push did not grow the stack");

  a_trav_fill_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> $stable(fill_q))
    else $error("fill count changed during traverse");

endmodule
